[rtl/core/wpsp_pkg.sv]
package wpsp_pkg;

   // Chunk identifiers as they appear after four little-endian bytes
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [31:0] RATE_RESET    = 32'd48000;
   localparam logic [15:0] FMT_PCM       = 16'd1;
   localparam logic [15:0] PCM_BITS      = 16'd16;
   localparam logic [31:0] FMT_BASE_SIZE = 32'd16;
   localparam logic [30:0] FRAMES_MAX    = 31'h7FFF_FFFF;

   // Status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_SHORT_HDR   = 4'd1;
   localparam logic [3:0] ST_NOT_RIFF    = 4'd2;
   localparam logic [3:0] ST_NOT_WAVE    = 4'd3;
   localparam logic [3:0] ST_NO_FMT      = 4'd4;
   localparam logic [3:0] ST_UNSUPPORTED = 4'd5;
   localparam logic [3:0] ST_NO_DATA     = 4'd6;
   localparam logic [3:0] ST_TRUNCATED   = 4'd7;
   localparam logic [3:0] ST_BAD_ALIGN   = 4'd8;

   // Result queue
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic               is_status;
      logic signed [15:0] sample;
      logic [15:0]        channel_index;
      logic [3:0]         status;
      logic [15:0]        channel_count;
      logic [30:0]        frame_count;
      logic               run_end;
   } rsp_item_type;

endpackage

[rtl/core/wav_pcm16_stream_parser_top.sv]
// Channel  | Direction | tdata (low bit up)                         | tuser     | tlast
// ---------+-----------+--------------------------------------------+-----------+------------
// req_     | in        | byte_value[7:0]                            | -         | end_of_file
// rsp_     | out       | sample, channel_index, status,             | is_status | run_end
//          |           | channel_count, frame_count, 5 zero bits    |           |
// csr_     | in        | csr_wdata = required_rate[31:0]            | -         | -
//
// One request per cycle while req_tready is high: every byte is parsed in the cycle it is accepted.
// A byte yields zero, one or two results (a sample, the status, or both); they
// drain one per cycle while rsp_tready is high, through a four-entry result
// queue, and req_tready drops only when fewer than two queue entries are free.
// Reset is synchronous and active high; it restores the parser state, empties
// the queue and sets required_rate to 48000. No clearing pass is needed.
// Stalls on rsp_ hold the queue head; parsing continues until fewer than two queue entries are free.
module wav_pcm16_stream_parser_top (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] byte_value
   input  logic                             req_tlast,   // end_of_file
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] sample, [31:16] channel_index, [35:32] status,
   // [51:36] channel_count, [82:52] frame_count, [87:83] zero
   output logic [wpsp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,   // is_status
   output logic                             rsp_tlast,   // run_end
   // configuration
   input  logic                             csr_we,
   input  logic [31:0]                      csr_wdata    // required_rate
);

   typedef enum logic [2:0] {
      PH_RIFF,
      PH_FMT,
      PH_SKIP,
      PH_DHDR,
      PH_DATA,
      PH_TAIL,
      PH_FAIL
   } phase_type;

   localparam int PTR_W = wpsp_pkg::RSP_PTR_W;
   localparam int CNT_W = wpsp_pkg::RSP_CNT_W;

   // configuration register
   logic [31:0] required_rate_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [4:0]  sbc_ff, sbc_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] fmt_size_ff, fmt_size_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] afmt_ff, afmt_in;
   logic [15:0] chans_ff, chans_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [31:0] drx_ff, drx_in;
   logic [31:0] fstart_ff, fstart_in;
   logic [15:0] offset_ff, offset_in;
   logic [30:0] frames_ff, frames_in;
   logic [7:0]  low_ff, low_in;
   logic [3:0]  err_ff, err_in;

   // per-byte results
   logic                      req_fire;
   logic                      smp_emit;
   wpsp_pkg::rsp_item_type    res0, res1;
   logic [1:0]                push_n;

   // result queue
   wpsp_pkg::rsp_item_type    q_mem [wpsp_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]          wr_ff, rd_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      pop;
   wpsp_pkg::rsp_item_type    head;

   assign req_fire = req_tvalid && req_tready;

   // Parse one byte: update the phase and the header fields, produce results.
   always_comb begin
      logic [4:0]  pos;
      logic        fits;
      logic [16:0] off_nx;
      logic [31:0] drx_nx;
      logic [3:0]  st;
      logic signed [15:0] smp_val;
      logic [15:0] smp_ch;

      phase_in  = phase_ff;
      sbc_in    = sbc_ff;
      shift_in  = shift_ff;
      fmt_size_in = fmt_size_ff;
      skip_in   = skip_ff;
      afmt_in   = afmt_ff;
      chans_in  = chans_ff;
      bits_in   = bits_ff;
      rate_in   = rate_ff;
      align_in  = align_ff;
      dsize_in  = dsize_ff;
      drx_in    = drx_ff;
      fstart_in = fstart_ff;
      offset_in = offset_ff;
      frames_in = frames_ff;
      low_in    = low_ff;
      err_in    = err_ff;
      smp_emit  = 1'b0;
      smp_val   = '0;
      smp_ch    = '0;
      st        = wpsp_pkg::ST_OK;

      pos    = sbc_ff;
      fits   = ({1'b0, fstart_ff} + {17'd0, align_ff}) <= {1'b0, dsize_ff};
      off_nx = {1'b0, offset_ff} + 17'd1;
      drx_nx = drx_ff + 32'd1;

      // Shift in header bytes, little endian
      if (phase_ff == PH_RIFF || phase_ff == PH_FMT || phase_ff == PH_DHDR) begin
         shift_in = {req_tdata, shift_ff[31:8]};
      end

      case (phase_ff)
         PH_RIFF: begin
            sbc_in = pos + 5'd1;
            if (pos == 5'd3 && shift_in != wpsp_pkg::ID_RIFF) begin
               err_in   = wpsp_pkg::ST_NOT_RIFF;
               phase_in = PH_FAIL;
            end else if (pos == 5'd11) begin
               if (shift_in != wpsp_pkg::ID_WAVE) begin
                  err_in   = wpsp_pkg::ST_NOT_WAVE;
                  phase_in = PH_FAIL;
               end else begin
                  phase_in = PH_FMT;
                  sbc_in   = '0;
               end
            end
         end
         PH_FMT: begin
            sbc_in = pos + 5'd1;
            if (pos == 5'd3 && shift_in != wpsp_pkg::ID_FMT) begin
               err_in   = wpsp_pkg::ST_NO_FMT;
               phase_in = PH_FAIL;
            end else if (pos == 5'd7) begin
               fmt_size_in = shift_in;
            end else if (pos == 5'd9) begin
               afmt_in = shift_in[31:16];
            end else if (pos == 5'd11) begin
               chans_in = shift_in[31:16];
            end else if (pos == 5'd15) begin
               rate_in = shift_in;
            end else if (pos == 5'd21) begin
               align_in = shift_in[31:16];
            end else if (pos == 5'd23) begin
               bits_in = shift_in[31:16];
               // Check the format once the last fixed fmt field is in
               if (fmt_size_ff < wpsp_pkg::FMT_BASE_SIZE || afmt_ff != wpsp_pkg::FMT_PCM ||
                   bits_in != wpsp_pkg::PCM_BITS || rate_ff != required_rate_ff) begin
                  err_in   = wpsp_pkg::ST_UNSUPPORTED;
                  phase_in = PH_FAIL;
               end else if (align_ff == 16'd0 ||
                            {1'b0, align_ff} < {chans_ff, 1'b0}) begin
                  err_in   = wpsp_pkg::ST_BAD_ALIGN;
                  phase_in = PH_FAIL;
               end else begin
                  skip_in = (fmt_size_ff - wpsp_pkg::FMT_BASE_SIZE) +
                            {31'd0, fmt_size_ff[0]};
                  if (skip_in == 32'd0) begin
                     phase_in = PH_DHDR;
                     sbc_in   = '0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_in == 32'd0) begin
               phase_in = PH_DHDR;
               sbc_in   = '0;
            end
         end
         PH_DHDR: begin
            sbc_in = pos + 5'd1;
            if (pos == 5'd3 && shift_in != wpsp_pkg::ID_DATA) begin
               err_in   = wpsp_pkg::ST_NO_DATA;
               phase_in = PH_FAIL;
            end else if (pos == 5'd7) begin
               dsize_in  = shift_in;
               drx_in    = '0;
               fstart_in = '0;
               offset_in = '0;
               phase_in  = (shift_in == 32'd0) ? PH_TAIL : PH_DATA;
            end
         end
         PH_DATA: begin
            if ({1'b0, offset_ff} < {chans_ff, 1'b0}) begin
               if (!offset_ff[0]) begin
                  low_in = req_tdata;
               end else if (fits) begin
                  smp_emit = 1'b1;
                  smp_val  = {req_tdata, low_ff};
                  smp_ch   = {1'b0, offset_ff[15:1]};
               end
            end
            drx_in = drx_nx;
            if (off_nx >= {1'b0, align_ff}) begin
               offset_in = '0;
               fstart_in = drx_nx;
               if (fits && frames_ff < wpsp_pkg::FRAMES_MAX) begin
                  frames_in = frames_ff + 31'd1;
               end
            end else begin
               offset_in = off_nx[15:0];
            end
            if (drx_nx == dsize_ff) begin
               phase_in = PH_TAIL;
            end
         end
         default: begin
         end
      endcase

      case (phase_in)
         PH_RIFF, PH_FMT: st = wpsp_pkg::ST_SHORT_HDR;
         PH_SKIP, PH_DHDR: st = wpsp_pkg::ST_NO_DATA;
         PH_DATA: st = wpsp_pkg::ST_TRUNCATED;
         PH_TAIL: st = wpsp_pkg::ST_OK;
         default: st = err_in;
      endcase

      res1.is_status     = 1'b1;
      res1.sample        = '0;
      res1.channel_index = '0;
      res1.status        = st;
      res1.channel_count = chans_in;
      res1.frame_count   = frames_in;
      res1.run_end       = 1'b1;

      if (smp_emit) begin
         res0.is_status     = 1'b0;
         res0.sample        = smp_val;
         res0.channel_index = smp_ch;
         res0.status        = '0;
         res0.channel_count = '0;
         res0.frame_count   = '0;
         res0.run_end       = !req_tlast;
      end else begin
         res0 = res1;
      end

      push_n = req_fire ? ({1'b0, smp_emit} + {1'b0, req_tlast}) : 2'd0;

      // Drop all parse state after the last byte of the file
      if (req_tlast) begin
         phase_in  = PH_RIFF;
         sbc_in    = '0;
         shift_in  = '0;
         fmt_size_in = '0;
         skip_in   = '0;
         afmt_in   = '0;
         chans_in  = '0;
         bits_in   = '0;
         rate_in   = '0;
         align_in  = '0;
         dsize_in  = '0;
         drx_in    = '0;
         fstart_in = '0;
         offset_in = '0;
         frames_in = '0;
         low_in    = '0;
         err_in    = wpsp_pkg::ST_OK;
      end
   end

   // Parse state advances only on an accepted request; the rate register on a csr_we write.
   always_ff @(posedge clock) begin
      if (reset) begin
         required_rate_ff <= wpsp_pkg::RATE_RESET;
         phase_ff  <= PH_RIFF;
         sbc_ff    <= '0;
         shift_ff  <= '0;
         fmt_size_ff <= '0;
         skip_ff   <= '0;
         afmt_ff   <= '0;
         chans_ff  <= '0;
         bits_ff   <= '0;
         rate_ff   <= '0;
         align_ff  <= '0;
         dsize_ff  <= '0;
         drx_ff    <= '0;
         fstart_ff <= '0;
         offset_ff <= '0;
         frames_ff <= '0;
         low_ff    <= '0;
         err_ff    <= wpsp_pkg::ST_OK;
      end else begin
         if (csr_we) begin
            required_rate_ff <= csr_wdata;
         end
         if (req_fire) begin
            phase_ff  <= phase_in;
            sbc_ff    <= sbc_in;
            shift_ff  <= shift_in;
            fmt_size_ff <= fmt_size_in;
            skip_ff   <= skip_in;
            afmt_ff   <= afmt_in;
            chans_ff  <= chans_in;
            bits_ff   <= bits_in;
            rate_ff   <= rate_in;
            align_ff  <= align_in;
            dsize_ff  <= dsize_in;
            drx_ff    <= drx_in;
            fstart_ff <= fstart_in;
            offset_ff <= offset_in;
            frames_ff <= frames_in;
            low_ff    <= low_in;
            err_ff    <= err_in;
         end
      end
   end

   // Result queue: up to two writes per cycle, one read.
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = cnt_ff <= CNT_W'(wpsp_pkg::RSP_DEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem[wr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         q_mem[PTR_W'(wr_ff + PTR_W'(1))] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= PTR_W'(wr_ff + PTR_W'(push_n));
         if (pop) begin
            rd_ff <= PTR_W'(rd_ff + PTR_W'(1));
         end
         cnt_ff <= CNT_W'(cnt_ff + CNT_W'(push_n) - CNT_W'(pop));
      end
   end

   assign head      = q_mem[rd_ff];
   assign rsp_tdata = {5'd0, head.frame_count, head.channel_count, head.status,
                       head.channel_index, head.sample};
   assign rsp_tuser = head.is_status;
   assign rsp_tlast = head.run_end;

endmodule

[rtl/core/wpsp_checker.sv]
module wpsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wpsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // A status result always closes the run of its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("status result without tlast");

   // Sample results carry no status, channel count or frame count
   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[82:32] == '0)
      else $error("sample result with status fields set");

   // Status results carry no sample and a legal code
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[31:0] == '0 && rsp_tdata[35:32] <= wpsp_pkg::ST_BAD_ALIGN)
      else $error("malformed status result");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind wav_pcm16_stream_parser_top wpsp_checker u_wpsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
